// ===== design/button_debounce_long_press_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication.
`define BDLP_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("bdlp assertion failed");

// Next-cycle implication.
`define BDLP_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("bdlp assertion failed");

`endif

// ===== design/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debounce and long-press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int IDX_W       = 4;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_AW      = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET    = 16'd100;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] STARTUP_RESET     = 16'd1000;
    localparam logic             PRESSED_LVL_RESET = 1'b1;
    localparam logic [CFG_W-1:0] LONG_MASK_RESET   = 16'd32;

    typedef enum logic [CFG_AW-1:0] {
        REG_DEBOUNCE_MS    = 3'd0,
        REG_LONG_PRESS_MS  = 3'd1,
        REG_STARTUP_MS     = 3'd2,
        REG_PRESSED_LEVEL  = 3'd3,
        REG_LONG_MASK      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] startup_ignore_ms;
        logic             pressed_level;
        logic [CFG_W-1:0] long_action_mask;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  button_index;
        logic [TIME_W-1:0] now_ms;
        logic              level;
        logic              level_valid;
    } evt_t;

    typedef struct packed {
        logic              held;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] last_change;
    } entry_t;

    typedef struct packed {
        logic   write;
        entry_t entry;
        logic   fire;
        logic   is_long;
    } eval_t;

endpackage

// ===== design/bdlp_eval.sv =====
// ----------------------------------------------------------------------------
// bdlp_eval
// Judges one pin-change event against its button's stored entry and the
// configuration; gives the updated entry and any action to report.
// ----------------------------------------------------------------------------
module bdlp_eval
    import bdlp_pkg::*;
(
    input  cfg_t   cfg,
    input  evt_t   evt,
    input  entry_t cur,
    output eval_t  res
);

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held_time;
    logic              idx_ok;
    logic              pass;
    logic              is_press;
    logic              has_long;

    assign idx_ok       = (int'(evt.button_index) < NUM_BUTTONS);
    assign since_change = evt.now_ms - cur.last_change;
    assign held_time    = evt.now_ms - cur.press_start;
    assign pass         = idx_ok
                       && (since_change > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms})
                       && (evt.now_ms > {{(TIME_W-CFG_W){1'b0}}, cfg.startup_ignore_ms});
    assign is_press     = (evt.level == cfg.pressed_level);
    assign has_long     = cfg.long_action_mask[evt.button_index];

    always_comb begin
        res.write   = pass;
        res.entry   = cur;
        res.fire    = 1'b0;
        res.is_long = 1'b0;
        if (pass) begin
            res.entry.last_change = evt.now_ms;
            if (evt.level_valid) begin
                if (has_long) begin
                    if (is_press) begin
                        res.entry.held        = 1'b1;
                        res.entry.press_start = evt.now_ms;
                    end else begin
                        res.entry.held        = 1'b0;
                        res.entry.press_start = '0;
                        res.fire              = cur.held;
                        res.is_long = (held_time >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms});
                    end
                end else begin
                    res.fire = is_press;
                end
            end
        end
    end

endmodule

// ===== design/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Per-button debounce with short and long press reporting.
// ----------------------------------------------------------------------------
// Usage: pin-change events arrive as beats on the s_ channel (button index,
// millisecond timestamp, level and a level-read flag). Each beat gives zero
// or one action beat on the m_ channel (button index and a long flag).
// Each accepted event is registered in the evaluation stage, and its action
// beat in the output register on m_. One event is taken per cycle unless that
// stage stalls: state RAM is read at acceptance, written back as the event
// leaves it, and forwarded so a back-to-back event on that button sees it.
// Reset clears the configuration to its defaults and marks every button's
// state entry as zero through per-entry valid bits; no clearing pass runs
// and events are taken right after reset.
// When the receiver stalls, the action register holds its beat and the
// evaluation stage keeps working until it has an action of its own to
// deliver; only then does s_ready drop. The output register separates the
// two sides, so a waiting action never blocks events that produce none.
// Configuration writes take effect at the next clock edge and are meant to
// happen while the block is idle.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_macros.svh"

module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IDX_W-1:0]  s_button_index,
    input  logic [TIME_W-1:0] s_now_ms,
    input  logic              s_level,
    input  logic              s_level_valid,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_pressed_button,
    output logic              m_is_long
);

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms       <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms     <= LONG_PRESS_RESET;
            cfg_reg.startup_ignore_ms <= STARTUP_RESET;
            cfg_reg.pressed_level     <= PRESSED_LVL_RESET;
            cfg_reg.long_action_mask  <= LONG_MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_DEBOUNCE_MS:   cfg_reg.debounce_ms       <= cfg_wr_data;
                REG_LONG_PRESS_MS: cfg_reg.long_press_ms     <= cfg_wr_data;
                REG_STARTUP_MS:    cfg_reg.startup_ignore_ms <= cfg_wr_data;
                REG_PRESSED_LEVEL: cfg_reg.pressed_level     <= cfg_wr_data[0];
                REG_LONG_MASK:     cfg_reg.long_action_mask  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Handshake and stage control.
    logic   s_accept;
    logic   s1_valid_reg, s1_valid_next;
    logic   s1_adv;
    logic   out_load;
    logic   m_valid_reg, m_valid_next;
    evt_t   s1_evt_reg;
    eval_t  ev;

    assign s_accept = s_valid && s_ready;

    // The evaluation stage moves on unless it holds an action while the
    // output register is full and not being emptied.
    assign s1_adv  = s1_valid_reg && (!ev.fire || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign out_load = s1_adv && ev.fire;

    // State RAM: one entry per button, synchronous read at acceptance.
    entry_t            mem [NUM_BUTTONS];
    entry_t            rd_reg;
    logic [NUM_BUTTONS-1:0] entry_valid_reg;
    logic [BTN_AW-1:0] rd_addr;
    logic [BTN_AW-1:0] s1_addr;
    logic              wr_en;

    assign rd_addr = s_button_index[BTN_AW-1:0];
    assign s1_addr = s1_evt_reg.button_index[BTN_AW-1:0];
    assign wr_en   = s1_adv && ev.write;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[s1_addr] <= ev.entry;
        end
    end

    // Entries never written read as zero, matching the reset state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (wr_en) begin
            entry_valid_reg[s1_addr] <= 1'b1;
        end
    end

    // Write-back copy for forwarding. A read issued at the same edge as a
    // write returns the old data, and that write is always the most recent
    // one, so a match on its address supplies the current entry.
    logic              wb_valid_reg;
    logic [BTN_AW-1:0] wb_addr_reg;
    entry_t            wb_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else if (wr_en) begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= ev.entry;
        end
    end

    entry_t cur_entry;

    always_comb begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr)) begin
            cur_entry = wb_data_reg;
        end else if (entry_valid_reg[s1_addr]) begin
            cur_entry = rd_reg;
        end else begin
            cur_entry = '0;
        end
    end

    // Event stage register.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_evt_reg.button_index <= s_button_index;
            s1_evt_reg.now_ms       <= s_now_ms;
            s1_evt_reg.level        <= s_level;
            s1_evt_reg.level_valid  <= s_level_valid;
        end
    end

    bdlp_eval u_eval (
        .cfg (cfg_reg),
        .evt (s1_evt_reg),
        .cur (cur_entry),
        .res (ev)
    );

    // Output register.
    logic [IDX_W-1:0] m_pressed_button_reg;
    logic             m_is_long_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pressed_button_reg <= s1_evt_reg.button_index;
            m_is_long_reg        <= ev.is_long;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pressed_button = m_pressed_button_reg;
    assign m_is_long        = m_is_long_reg;

    // A stalled evaluation stage must hold off new events.
    `BDLP_ASSERT_IMP(a_stall_blocks_input, s1_valid_reg && !s1_adv, !s_ready)
    // State is written back only by an event leaving the evaluation stage.
    `BDLP_ASSERT_IMP(a_write_from_stage, wr_en, s1_valid_reg && s1_adv)
    // A new action never overwrites one still waiting for the receiver.
    `BDLP_ASSERT_IMP(a_no_overwrite, out_load, !m_valid_reg || m_ready)
    // A written entry is marked valid from the next cycle on.
    `BDLP_ASSERT_NXT(a_entry_marked, wr_en, entry_valid_reg[$past(s1_addr)])

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for button_debounce_long_press
// Drives pin-change events into the block and checks every press action it
// reports against a cycle-free model of the debounce and long-press rules.
// A short directed part covers the edges of the lockout, the startup window
// and the long-press threshold. Random phases then sweep the settings and
// the idle patterns of both channels.
// ----------------------------------------------------------------------------
module testbench;
    import bdlp_pkg::*;

    // Generous guard against a hung handshake; a correct run needs far less.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Each accepted event passes the evaluation stage and the output register.
    // Events that give no action can still be in flight after the last action,
    // so every quiet period adds a settling wait after it.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned RANDOM_PHASES = 8;

    typedef struct packed {
        logic [IDX_W-1:0] button;
        logic             is_long;
    } action_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              cfg_wr_en      = 1'b0;
    logic [CFG_AW-1:0] cfg_wr_index   = '0;
    logic [CFG_W-1:0]  cfg_wr_data    = '0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [IDX_W-1:0]  s_button_index = '0;
    logic [TIME_W-1:0] s_now_ms       = '0;
    logic              s_level        = 1'b0;
    logic              s_level_valid  = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [IDX_W-1:0]  m_pressed_button;
    logic              m_is_long;

    button_debounce_long_press u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_button_index   (s_button_index),
        .s_now_ms         (s_now_ms),
        .s_level          (s_level),
        .s_level_valid    (s_level_valid),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pressed_button (m_pressed_button),
        .m_is_long        (m_is_long)
    );

    // 10 ns period: the clock flips every half period.
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Model state. The settings mirror the registers as last written, and the
    // per-button arrays mirror the block's state table.
    // ------------------------------------------------------------------------
    cfg_t              cur_cfg;
    logic [TIME_W-1:0] btn_last_change [NUM_BUTTONS];
    logic [TIME_W-1:0] btn_press_start [NUM_BUTTONS];
    bit                btn_held        [NUM_BUTTONS];
    // Last level sent per button, so that random events mostly alternate.
    bit                last_level_sent [NUM_BUTTONS];

    action_t           pending_actions[$];
    int unsigned       error_count  = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct     = 0;

    // Works out what one accepted event does to the button table and queues
    // the action it fires, if any.
    function automatic void apply_pin_event(input evt_t ev);
        int unsigned       b;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] hold_time;
        bit                is_press;
        bit                was_held;
        action_t           act;
        b = 32'(ev.button_index);
        if (b >= NUM_BUTTONS) begin
            return;
        end
        // Differences wrap modulo 2^32; the lockout must be exceeded.
        since_change = ev.now_ms - btn_last_change[b];
        if (since_change <= TIME_W'(cur_cfg.debounce_ms)) begin
            return;
        end
        if (ev.now_ms <= TIME_W'(cur_cfg.startup_ignore_ms)) begin
            return;
        end
        // From here on the event counts as a change even if unreadable.
        btn_last_change[b] = ev.now_ms;
        if (!ev.level_valid) begin
            return;
        end
        is_press = (ev.level == cur_cfg.pressed_level);
        act.button = IDX_W'(b);
        if (cur_cfg.long_action_mask[b]) begin
            if (is_press) begin
                // A second press while held simply restarts the hold.
                btn_held[b]        = 1'b1;
                btn_press_start[b] = ev.now_ms;
                return;
            end
            was_held           = btn_held[b];
            hold_time          = ev.now_ms - btn_press_start[b];
            btn_held[b]        = 1'b0;
            btn_press_start[b] = '0;
            if (was_held) begin
                act.is_long = (hold_time >= TIME_W'(cur_cfg.long_press_ms));
                pending_actions.push_back(act);
            end
            return;
        end
        // Buttons without a long action fire on press; a release leaves the
        // held state alone.
        if (is_press) begin
            act.is_long = 1'b0;
            pending_actions.push_back(act);
        end
    endfunction

    function automatic evt_t make_event(input int unsigned b, input logic [TIME_W-1:0] t,
                                        input bit lvl, input bit vld);
        evt_t ev;
        ev.button_index = IDX_W'(b);
        ev.now_ms       = t;
        ev.level        = lvl;
        ev.level_valid  = vld;
        return ev;
    endfunction

    // Builds a random event. Most of them land just past the lockout and
    // alternate press and release, so that buttons really go through their
    // hold cycle; the rest probe the lockout edge, the long-press threshold,
    // arbitrary timestamps and the wrap of the millisecond counter.
    function automatic evt_t random_event();
        evt_t              ev;
        int unsigned       b;
        int unsigned       pick;
        logic [TIME_W-1:0] lockout;
        logic [TIME_W-1:0] hold_min;
        b        = $urandom_range(NUM_BUTTONS - 1);
        lockout  = TIME_W'(cur_cfg.debounce_ms);
        hold_min = TIME_W'(cur_cfg.long_press_ms);
        pick     = $urandom_range(99);
        ev.button_index = IDX_W'(b);
        if (pick < 8) begin
            ev.now_ms = btn_last_change[b] + $urandom_range(lockout);
        end else if (pick < 12) begin
            ev.now_ms = btn_last_change[b] + lockout;
        end else if (pick < 16) begin
            ev.now_ms = btn_last_change[b] + lockout + 1;
        end else if (pick < 26 && btn_held[b]) begin
            ev.now_ms = btn_press_start[b] + hold_min - 1 + $urandom_range(2);
        end else if (pick >= 26 && pick < 30) begin
            ev.now_ms = $urandom;
        end else if (pick >= 30 && pick < 33) begin
            ev.now_ms = 32'hFFFF_FFFF - $urandom_range(4000);
        end else begin
            ev.now_ms = btn_last_change[b] + lockout + 1 + $urandom_range(2 * hold_min + 50);
        end
        if ($urandom_range(99) < 80) begin
            if (cur_cfg.long_action_mask[b]) begin
                ev.level = btn_held[b] ? ~cur_cfg.pressed_level : cur_cfg.pressed_level;
            end else begin
                ev.level = ~last_level_sent[b];
            end
        end else begin
            ev.level = 1'($urandom_range(1));
        end
        last_level_sent[b] = ev.level;
        ev.level_valid     = ($urandom_range(99) < 92);
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Inputs change on the falling edge; acceptance is judged on the
    // rising edge. Valid stays high across back-to-back beats and only drops
    // for an idle cycle or a quiet period.
    // ------------------------------------------------------------------------
    task automatic send_event(input evt_t ev);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_button_index <= ev.button_index;
        s_now_ms       <= ev.now_ms;
        s_level        <= ev.level;
        s_level_valid  <= ev.level_valid;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        apply_pin_event(ev);
    endtask

    // Stops sending, waits for every queued action and lets any event that
    // gives no action clear the pipeline. Settings are only changed after it.
    task automatic wait_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEBOUNCE_MS:   cur_cfg.debounce_ms       = value;
            REG_LONG_PRESS_MS: cur_cfg.long_press_ms     = value;
            REG_STARTUP_MS:    cur_cfg.startup_ignore_ms = value;
            REG_PRESSED_LEVEL: cur_cfg.pressed_level     = value[0];
            REG_LONG_MASK:     cur_cfg.long_action_mask  = value;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold,
                                  input logic [CFG_W-1:0] startup, input bit lvl,
                                  input logic [CFG_W-1:0] mask);
        write_reg(REG_DEBOUNCE_MS, debounce);
        write_reg(REG_LONG_PRESS_MS, hold);
        write_reg(REG_STARTUP_MS, startup);
        write_reg(REG_PRESSED_LEVEL, CFG_W'(lvl));
        write_reg(REG_LONG_MASK, mask);
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Ready is redrawn every falling edge according to the current
    // stall rate; a rate of zero keeps it high.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Each action beat is matched against the oldest predicted action.
    always @(posedge aclk) begin
        action_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_actions.size() == 0) begin
                $display("%0t: unexpected action beat, expected none, got button %0d long %0b",
                         $time, m_pressed_button, m_is_long);
                error_count++;
            end else begin
                want = pending_actions.pop_front();
                if (m_pressed_button !== want.button || m_is_long !== want.is_long) begin
                    $display({"%0t: action mismatch, expected button %0d long %0b, ",
                              "got button %0d long %0b"},
                             $time, want.button, want.is_long, m_pressed_button, m_is_long);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Runs at the reset settings: lockout 100 ms, long press 1000 ms, startup
    // window 1000 ms, pressed level high, and only button 5 with a long action.
    task automatic test_directed_cases();
        // Startup window: the boundary itself is still ignored, one past it is not.
        send_event(make_event(3, 32'd1000, 1'b1, 1'b1));
        send_event(make_event(3, 32'd1001, 1'b1, 1'b1));
        // Lockout, its exact edge, then the first accepted release of a plain button.
        send_event(make_event(3, 32'd1050, 1'b0, 1'b1));
        send_event(make_event(3, 32'd1101, 1'b0, 1'b1));
        send_event(make_event(3, 32'd1102, 1'b0, 1'b1));
        // Long-action button: a release that was never pressed fires nothing.
        send_event(make_event(5, 32'd2000, 1'b0, 1'b1));
        // A repeated press restarts the hold, so this release is one short of long.
        send_event(make_event(5, 32'd2200, 1'b1, 1'b1));
        send_event(make_event(5, 32'd2400, 1'b1, 1'b1));
        send_event(make_event(5, 32'd3399, 1'b0, 1'b1));
        // Held for exactly the threshold: long.
        send_event(make_event(5, 32'd3600, 1'b1, 1'b1));
        send_event(make_event(5, 32'd4600, 1'b0, 1'b1));
        // An unreadable level still arms the lockout for the next event.
        send_event(make_event(7, 32'd5000, 1'b1, 1'b0));
        send_event(make_event(7, 32'd5050, 1'b1, 1'b1));
        send_event(make_event(7, 32'd5101, 1'b1, 1'b1));
        // Largest index and timestamps at the top of the range.
        send_event(make_event(15, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_event(make_event(0, 32'hFFFF_FFF0, 1'b1, 1'b1));
        // A hold that spans the wrap of the millisecond counter.
        send_event(make_event(5, 32'hFFFF_FF00, 1'b1, 1'b1));
        send_event(make_event(5, 32'h0000_0400, 1'b0, 1'b1));
        // After the wrap, small timestamps fall back inside the startup window.
        send_event(make_event(12, 32'h0000_0300, 1'b1, 1'b1));
        // Alternating bit patterns in the timestamp, at both levels.
        send_event(make_event(9, 32'h5555_5555, 1'b0, 1'b1));
        send_event(make_event(10, 32'hAAAA_AAAA, 1'b1, 1'b1));
        wait_quiet();
    endtask

    // The mask is looked up per event: a release while the action is masked
    // off leaves the button held, and the release after it is unmasked again
    // measures from the original press.
    task automatic test_mask_change_while_held();
        send_event(make_event(5, 32'd4096, 1'b1, 1'b1));
        wait_quiet();
        write_reg(REG_LONG_MASK, 16'h0000);
        send_event(make_event(5, 32'd6000, 1'b0, 1'b1));
        wait_quiet();
        write_reg(REG_LONG_MASK, LONG_MASK_RESET);
        send_event(make_event(5, 32'd6500, 1'b0, 1'b1));
        wait_quiet();
    endtask

    // One random phase: new settings, one idle pattern, then a batch of events.
    // Phase 0 keeps the reset timings; phases 1 to 3 pin them at their extremes.
    task automatic test_random_phase(input int unsigned phase, input int unsigned count);
        case (phase)
            0: write_all_regs(DEBOUNCE_RESET, LONG_PRESS_RESET, STARTUP_RESET,
                              PRESSED_LVL_RESET, CFG_W'($urandom));
            1: write_all_regs(16'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF);
            2: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000);
            3: write_all_regs(16'd0, 16'hFFFF, 16'd0, 1'b1, 16'hFFFF);
            default: write_all_regs(CFG_W'($urandom_range(300)), CFG_W'($urandom_range(3000)),
                                    CFG_W'($urandom_range(2000)), 1'($urandom_range(1)),
                                    CFG_W'($urandom));
        endcase
        case (phase % 4)
            0: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1: begin
                send_idle_pct = 75;
                stall_pct     = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct     = 75;
            end
            default: begin
                send_idle_pct = 36;
                stall_pct     = 36;
            end
        endcase
        repeat (count) send_event(random_event());
        wait_quiet();
    endtask

    initial begin
        cur_cfg.debounce_ms       = DEBOUNCE_RESET;
        cur_cfg.long_press_ms     = LONG_PRESS_RESET;
        cur_cfg.startup_ignore_ms = STARTUP_RESET;
        cur_cfg.pressed_level     = PRESSED_LVL_RESET;
        cur_cfg.long_action_mask  = LONG_MASK_RESET;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_last_change[i] = '0;
            btn_press_start[i] = '0;
            btn_held[i]        = 1'b0;
            last_level_sent[i] = 1'b0;
        end

        // Synchronous reset, held from the start and released on a falling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_mask_change_while_held();
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            test_random_phase(p, RANDOM_ITEMS / RANDOM_PHASES);
        end

        // wait_quiet at the end of each phase has already drained everything,
        // so any leftover here is a failure of its own.
        if (error_count == 0 && pending_actions.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
